// File: rtl/ucm_pkg.sv
// ----------------------------------------------------------------------------
// ucm_pkg
// Shared widths for the upward cone max matrix unit.
// ----------------------------------------------------------------------------
package ucm_pkg;

    localparam int DATA_W = 32;   // matrix element / result word
    localparam int CFG_W  = 11;   // matrix_size register

    typedef logic signed [DATA_W-1:0] word_t;

endpackage

// File: rtl/upward_cone_max_matrix_unit.sv
// ----------------------------------------------------------------------------
// upward_cone_max_matrix_unit
// Per-element maximum over the upward cone of a square matrix streamed in
// row-major order: out[i][j] = max(a[i][j], out[i-1][j-1..j+1]).
//
//   port group   dir   word contents (low bit first)
//   s_*          in    tdata[31:0] element
//   m_*          out   tdata[31:0] cone_max, tlast row_end, tuser matrix_end
//   cfg_*        in    cfg_wdata[10:0] matrix_size
//
// One word per cycle while m_tready does not stall the output; output valid in the cycle after input accept.
// The line store is read every cycle at the column of the next word and the
// one right of it, so its data is ready when the word arrives; the result is
// written back at accept time, bypassed to a same-cycle read.
// The output register is reloaded on the cycle it is taken, so a stall on
// m_tready stalls s_tready in the same cycle only while the output is full.
// Reset clears counts and sets the size to 1; the store needs no clearing.
// ----------------------------------------------------------------------------
module upward_cone_max_matrix_unit
    import ucm_pkg::*;
#(
    parameter int MAX_SIZE = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,    // [10:0] matrix_size
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,      // [31:0] element
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,      // [31:0] cone_max
    output logic              m_tlast,      // row_end
    output logic              m_tuser       // [0] matrix_end
);

    localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SW = AW + 1;

    logic [SW-1:0] size_reg;
    logic [SW-1:0] size_next;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic [AW-1:0] row_reg;
    logic [AW-1:0] row_next;
    word_t         left_reg;
    word_t         mid_above;
    word_t         right_raw;
    word_t         left_sel;
    word_t         right_sel;
    word_t         elem;
    word_t         result;
    logic          accept;
    logic          last_col;
    logic          last_row;
    logic          has_right;

    logic          out_valid_reg;
    word_t         out_data_reg;
    logic          out_last_reg;
    logic          out_end_reg;

    // ---------------- effective size on config write ----------------
    always_comb
    begin
        if (cfg_wdata == '0)
        begin
            size_next = SW'(1);
        end
        else if (32'(cfg_wdata) > 32'(MAX_SIZE))
        begin
            size_next = SW'(MAX_SIZE);
        end
        else
        begin
            size_next = SW'(cfg_wdata);
        end
    end

    // ---------------- position and neighbors ----------------
    assign accept    = s_tvalid && s_tready;
    assign last_col  = ({1'b0, col_reg} + SW'(1)) == size_reg;
    assign last_row  = ({1'b0, row_reg} + SW'(1)) == size_reg;
    assign has_right = !last_col;
    assign elem      = word_t'(s_tdata);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : AW'(row_reg + AW'(1));
            end
            else
            begin
                col_next = AW'(col_reg + AW'(1));
            end
        end
    end

    ucm_line_store #(
        .DEPTH (MAX_SIZE),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .we      (accept),
        .waddr   (col_reg),
        .wdata   (result),
        .raddr_a (col_next),
        .raddr_b (AW'(col_next + AW'(1))),
        .rdata_a (mid_above),
        .rdata_b (right_raw)
    );

    always_comb
    begin
        left_sel  = (col_reg != '0) ? left_reg : mid_above;
        right_sel = has_right ? right_raw : mid_above;
        result    = elem;
        if (row_reg != '0)
        begin
            if (left_sel > result)
            begin
                result = left_sel;
            end
            if (mid_above > result)
            begin
                result = mid_above;
            end
            if (right_sel > result)
            begin
                result = right_sel;
            end
        end
    end

    // ---------------- control state ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= SW'(1);
            col_reg       <= '0;
            row_reg       <= '0;
            left_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= size_next;
            end
            col_reg <= col_next;
            row_reg <= row_next;
            if (accept)
            begin
                left_reg <= mid_above;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- output payload ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
            out_last_reg <= last_col;
            out_end_reg  <= last_col && last_row;
        end
    end

    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

    // ---------------- assertions ----------------
    a_col_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, col_reg} < size_reg))
        else $error("column count beyond matrix size");

    a_row_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, row_reg} < size_reg))
        else $error("row count beyond matrix size");

    a_row_advance : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cfg_we && last_col && !last_row)
        |=> (col_reg == '0) && (row_reg == AW'($past(row_reg) + AW'(1))))
        else $error("row did not advance at end of row");

    a_first_row_pass : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (row_reg == '0)) |=> (m_tdata == $past(s_tdata)))
        else $error("first row word not passed through");

    a_end_needs_last : assert property (@(posedge clk) disable iff (!rst_n)
        $past(accept) |-> (!m_tuser || m_tlast))
        else $error("matrix end without row end");

endmodule

// File: rtl/ucm_line_store.sv
// ----------------------------------------------------------------------------
// ucm_line_store
// Previous-row line store: one write port, two registered read ports.
// A read of the address being written in the same cycle returns the new word.
// ----------------------------------------------------------------------------
module ucm_line_store
    import ucm_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  word_t         wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output word_t         rdata_a,
    output word_t         rdata_b
);

    word_t mem [DEPTH];
    word_t rdata_a_reg;
    word_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr_a))
        begin
            rdata_a_reg <= wdata;
        end
        else
        begin
            rdata_a_reg <= mem[raddr_a];
        end
        if (we && (waddr == raddr_b))
        begin
            rdata_b_reg <= wdata;
        end
        else
        begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for upward_cone_max_matrix_unit. Matrices of signed
// words are streamed in under several sizes, including the degenerate and
// oversize settings. Each accepted input word is run through a local model
// of the cone recurrence, and every output word is compared with the oldest
// queued prediction. Both stream sides idle at random, and one phase holds
// the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module testbench;
    import ucm_pkg::*;

    localparam int     MAX_SIZE       = 1024;
    localparam int     RANDOM_ITEMS   = 200;
    localparam int     LONG_STALL     = 120;
    localparam int     WATCHDOG_LIMIT = 1000;
    localparam int     DRAIN_CYCLES   = 8;
    localparam word_t  WORD_MIN       = 32'h8000_0000;
    localparam word_t  WORD_MAX       = 32'h7FFF_FFFF;

    typedef struct packed {
        word_t cone_max;
        logic  row_end;
        logic  matrix_end;
    } cone_word_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              m_tuser;

    // local copy of the block state
    word_t             row_copy [0:MAX_SIZE-1];
    word_t             left_above;
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [CFG_W-1:0]  size_reg;

    cone_word_t        pending_cone_max [$];
    int unsigned       mismatches;
    bit                gaps_on;
    bit                stall_request;

    upward_cone_max_matrix_unit #(
        .MAX_SIZE (MAX_SIZE)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic word_t rand_element();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 16) - 8;   // small values, many ties
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // out[i][j] = max(a[i][j], out[i-1][j-1..j+1]), edges clamped
    function automatic cone_word_t advance_cone(input word_t elem);
        int unsigned n;
        word_t       above;
        word_t       left_nb;
        word_t       right_nb;
        word_t       best;
        cone_word_t  r;
        n = (size_reg == 0) ? 1 :
            ((int'(size_reg) > MAX_SIZE) ? MAX_SIZE : int'(size_reg));
        above = row_copy[col_pos];
        best = elem;
        if (row_pos != 0)
        begin
            left_nb  = (col_pos > 0) ? left_above : above;
            right_nb = (col_pos + 1 < n) ? row_copy[col_pos + 1] : above;
            if (left_nb > best)
                best = left_nb;
            if (above > best)
                best = above;
            if (right_nb > best)
                best = right_nb;
        end
        left_above = above;
        row_copy[col_pos] = best;
        r.cone_max   = best;
        r.row_end    = (col_pos + 1 == n);
        r.matrix_end = r.row_end && (row_pos + 1 == n);
        if (r.row_end)
        begin
            col_pos = 0;
            row_pos = r.matrix_end ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return r;
    endfunction

    task automatic send_word(input word_t elem);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= elem;
        do @(posedge clk); while (s_tready !== 1'b1);
        pending_cone_max.push_back(advance_cone(elem));
    endtask

    task automatic drain_outputs();
        s_tvalid <= 1'b0;
        while (pending_cone_max.size() != 0)
            @(posedge clk);
    endtask

    // Size writes also restart the matrix at row 0, column 0.
    task automatic write_size(input logic [CFG_W-1:0] value);
        drain_outputs();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_reg = value;
        col_pos  = 0;
        row_pos  = 0;
    endtask

    // After reset the size is 1: every word is its own matrix.
    task automatic test_default_size();
        send_word(WORD_MIN);
        send_word(WORD_MAX);
        send_word('0);
        send_word('1);
    endtask

    task automatic test_size_zero();
        write_size('0);
        send_word(32'h5A5A_A5A5);
        send_word(32'hA5A5_5A5A);
    endtask

    // A single peak in a corner must spread one column per row and clamp
    // at both edges; two back-to-back matrices exercise the wrap.
    task automatic test_edge_clamp();
        word_t left_peak  [0:8];
        word_t right_peak [0:8];
        left_peak  = '{WORD_MAX, WORD_MIN, WORD_MIN,
                       WORD_MIN, WORD_MIN, '1,
                       WORD_MIN, WORD_MIN, WORD_MIN};
        right_peak = '{WORD_MIN, WORD_MIN, WORD_MAX,
                       '0, WORD_MIN, WORD_MIN,
                       WORD_MIN, WORD_MIN, WORD_MIN};
        write_size(CFG_W'(3));
        gaps_on = 1'b0;
        foreach (left_peak[k])
            send_word(left_peak[k]);
        foreach (right_peak[k])
            send_word(right_peak[k]);
        gaps_on = 1'b1;
    endtask

    // Full-width rows: largest legal size, then an oversize value that
    // saturates to it.
    task automatic test_large_size();
        write_size(CFG_W'(MAX_SIZE));
        repeat (4) send_word(rand_element());
        write_size('1);
        repeat (MAX_SIZE + 6) send_word(rand_element());
    endtask

    task automatic test_output_backpressure();
        write_size(CFG_W'(4));
        gaps_on = 1'b0;
        stall_request = 1'b1;
        repeat (40) send_word(rand_element());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_matrices();
        int unsigned sent;
        int unsigned n;
        int unsigned words;
        int          pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                n = 0;
            else if (pick < 14)
                n = $urandom_range(1, 6);
            else
                n = $urandom_range(7, 12);
            write_size(CFG_W'(n));
            if (n == 0)
                n = 1;
            gaps_on = ($urandom_range(0, 4) != 0);
            words = n * n * $urandom_range(1, 3);
            // leave some matrices unfinished before the next size write
            if ($urandom_range(0, 2) == 0)
                words = words + $urandom_range(1, n * n);
            repeat (words) send_word(rand_element());
            sent = sent + words;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        mismatches    = 0;
        gaps_on       = 1'b1;
        stall_request = 1'b0;
        left_above    = '0;
        col_pos       = 0;
        row_pos       = 0;
        size_reg      = CFG_W'(1);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_size();
        test_size_zero();
        test_edge_clamp();
        test_large_size();
        test_output_backpressure();
        test_random_matrices();

        drain_outputs();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output ready: random runs and gaps, plus one long hold on request.
    initial
    begin : sink_ready
        int gap;
        m_tready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        cone_word_t want;
        if (rst_n === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            if (pending_cone_max.size() == 0)
            begin
                $display("%0t: word with none expected: cone_max %0d tlast %b tuser %b",
                         $time, $signed(m_tdata), m_tlast, m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_cone_max.pop_front();
                if (m_tdata !== want.cone_max)
                begin
                    $display("%0t: cone_max expected %0d, got %0d",
                             $time, want.cone_max, $signed(m_tdata));
                    mismatches++;
                end
                if (m_tlast !== want.row_end)
                begin
                    $display("%0t: row_end expected %b, got %b",
                             $time, want.row_end, m_tlast);
                    mismatches++;
                end
                if (m_tuser !== want.matrix_end)
                begin
                    $display("%0t: matrix_end expected %b, got %b",
                             $time, want.matrix_end, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
                (m_tvalid === 1'b1 && m_tready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/ucm_pkg.sv
rtl/ucm_line_store.sv
rtl/upward_cone_max_matrix_unit.sv
sim/testbench.sv
